FILE: src/audio_history_ring_backdate_macros.svh
// Assertion macros for the audio history ring.
// Used by audio_history_ring_backdate.sv; expects clock and reset in scope.
`ifndef AUDIO_HISTORY_RING_BACKDATE_MACROS_SVH
`define AUDIO_HISTORY_RING_BACKDATE_MACROS_SVH

// Same-cycle implication, off during reset
`define AHRB_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset
`define AHRB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/ahrb_pkg.sv
// Shared constants, opcodes, types and the saturation function of the audio history ring.
// No dependencies.
package ahrb_pkg;

   // Geometry (both powers of two)
   localparam int RING_BLOCKS  = 1024;
   localparam int BLOCK_FRAMES = 128;
   localparam int RING_W       = $clog2(RING_BLOCKS);
   localparam int FRAME_W      = $clog2(BLOCK_FRAMES);
   localparam int SLOT_W       = RING_W + FRAME_W;
   localparam int STORE_DEPTH  = RING_BLOCKS * BLOCK_FRAMES;
   localparam int BLOCK_SHIFT  = FRAME_W;

   // Field widths
   localparam int OP_W          = 2;
   localparam int SAMPLE_IN_W   = 32;
   localparam int SAMPLE_W      = 16;
   localparam int WORD_W        = 32;
   localparam int READ_FRAME_W  = 7;
   localparam int RATE_W        = 18;
   localparam int LAG_W         = 16;
   localparam int SAMPLES_W     = 17;
   localparam int ENTRY_W       = 2 * SAMPLE_W;

   // Opcodes
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   // Register map
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = RATE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_LAG   = 1'd1;
   localparam logic [RATE_W-1:0]    RATE_RESET      = 18'd48000;

   // Saturation bounds
   localparam logic signed [SAMPLE_IN_W-1:0] SAT_MAX = 32'sd32767;
   localparam logic signed [SAMPLE_IN_W-1:0] SAT_MIN = -32'sd32768;

   // Microseconds to samples: floor(lat * rate / 1e6).
   // Drop the factor 2^6 by shift, then divide by 15625 through a reciprocal
   // that undershoots by at most one, fixed by one compare and add.
   localparam int USEC_PER_SEC  = 1000000;
   localparam int DIV_PRE_SHIFT = 6;
   localparam int DIV_ODD       = USEC_PER_SEC >> DIV_PRE_SHIFT;
   localparam int PROD_W        = WORD_W + RATE_W;
   localparam int Y_W           = PROD_W - DIV_PRE_SHIFT;
   localparam int SPLIT         = Y_W / 2;
   localparam int RECIP_SHIFT   = Y_W;
   localparam int RECIP_W       = 31;
   localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / DIV_ODD;
   localparam int PP_W          = (Y_W - SPLIT) + RECIP_W;
   localparam int SUM_W         = Y_W + RECIP_W + 1;
   localparam int Q_W           = RECIP_W;
   localparam int REM_W         = 16;
   localparam logic [REM_W-1:0] DIV_K = REM_W'(DIV_ODD);

   // Pipeline depth ahead of the result register
   localparam int NSTAGE = 6;

   // Fields that travel with an item down the pipeline
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [WORD_W-1:0]  wbc;
      logic [RING_W-1:0]  avail;
      logic [WORD_W-1:0]  lat;
      logic [ENTRY_W-1:0] data;
   } ahrb_carry_type;

   // Clamp a signed 32-bit sample into 16 bits
   function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [SAMPLE_IN_W-1:0] v);
      logic [SAMPLE_W-1:0] res;
      if (v > SAT_MAX) begin
         res = SAT_MAX[SAMPLE_W-1:0];
      end else if (v < SAT_MIN) begin
         res = SAT_MIN[SAMPLE_W-1:0];
      end else begin
         res = v[SAMPLE_W-1:0];
      end
      return res;
   endfunction

endpackage

FILE: src/audio_history_ring_backdate.sv
// Stereo audio history ring with backdate queries: store, write head, pipeline, outputs.
// Depends on ahrb_pkg and audio_history_ring_backdate_macros.svh.
//
// One word in, one word out, in order. The block takes a word every cycle unless req_stall is
// raised; each word passes through the pipeline stages and then the result register. The
// pipeline advances as a whole whenever the result register is empty or being taken,
// and the single-port frame store serves one write or one read per cycle. The store
// needs no clearing pass: the write head and a wrap flag tell which entries were ever
// written, and the others read as zero, so words are taken right after reset.
`include "audio_history_ring_backdate_macros.svh"

module audio_history_ring_backdate (
   input  logic                                    clock,
   input  logic                                    reset,
   // input words
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [ahrb_pkg::OP_W-1:0]               req_op,
   input  logic signed [ahrb_pkg::SAMPLE_IN_W-1:0] req_in_left,
   input  logic signed [ahrb_pkg::SAMPLE_IN_W-1:0] req_in_right,
   input  logic [ahrb_pkg::WORD_W-1:0]             req_read_block,
   input  logic [ahrb_pkg::READ_FRAME_W-1:0]       req_read_frame,
   input  logic [ahrb_pkg::WORD_W-1:0]             req_press_time_us,
   input  logic [ahrb_pkg::WORD_W-1:0]             req_now_us,
   // result words
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [ahrb_pkg::SAMPLE_W-1:0]    rsp_out_left,
   output logic signed [ahrb_pkg::SAMPLE_W-1:0]    rsp_out_right,
   output logic [ahrb_pkg::WORD_W-1:0]             rsp_back_block,
   output logic [ahrb_pkg::SAMPLES_W-1:0]          rsp_backdate_samples,
   output logic                                    rsp_was_clamped,
   output logic [ahrb_pkg::WORD_W-1:0]             rsp_press_latency_us,
   // configuration
   input  logic                                    csr_we,
   input  logic [ahrb_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [ahrb_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import ahrb_pkg::*;

   localparam int BLK_W = WORD_W - BLOCK_SHIFT;
   localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(BLOCK_FRAMES - 1);
   localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(STORE_DEPTH - 1);

   // Configuration
   logic [RATE_W-1:0] rate_ff;
   logic [LAG_W-1:0]  lag_ff;

   // Write head
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [WORD_W-1:0]  wbc_ff, wbc_in;
   logic               wrap_ff, wrap_in;

   // Handshake
   logic adv, acc, write_acc, read_acc;

   // Store
   logic [ENTRY_W-1:0] store_mem [STORE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [SLOT_W-1:0]  head_slot, rd_slot;
   logic [ENTRY_W-1:0] sat_pair;
   logic               seen_in, seen_ff;

   // Pipeline
   logic [NSTAGE-1:0]  vld_ff;
   ahrb_carry_type     carry_ff [NSTAGE];
   ahrb_carry_type     carry_in;
   logic [ENTRY_W-1:0] data_sel;
   logic [RING_W-1:0]  avail_in;
   logic [WORD_W-1:0]  lat_in;

   // Microsecond-to-sample math
   logic [PROD_W-1:0] prod_in, prod_ff;
   logic [Y_W-1:0]    y_val;
   logic [PP_W-1:0]   pph_in, ppl_in, pph_ff, ppl_ff;
   logic [REM_W-1:0]  ylo3_ff, ylo4_ff;
   logic [SUM_W-1:0]  sum_val;
   logic [Q_W-1:0]    qe_ff, q_in, q_ff;
   logic [REM_W-1:0]  qm_lo, rem_val;

   // Clamp
   logic [WORD_W-1:0]  back_val;
   logic [BLK_W-1:0]   blocks_val;
   logic               clamp_in, clamp_ff;
   logic [RING_W-1:0]  blk_in, blk_ff;
   logic [SAMPLES_W-1:0] samples_val;

   // Result register
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] left_ff, right_ff;
   logic [WORD_W-1:0]          back_block_ff, latency_ff;
   logic [SAMPLES_W-1:0]       samples_ff;
   logic                       was_clamped_ff;

   // Advance the whole pipe when the result register frees up
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign acc       = req_valid && adv;
   assign write_acc = acc && (req_op == OP_WRITE);
   assign read_acc  = acc && (req_op == OP_READ);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
         lag_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLE_RATE: rate_ff <= csr_wdata;
            CSR_FIXED_LAG:   lag_ff  <= csr_wdata[LAG_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the write head on each stored frame
   assign head_slot = {wbc_ff[RING_W-1:0], frame_ff};
   always_comb begin
      frame_in = frame_ff;
      wbc_in   = wbc_ff;
      wrap_in  = wrap_ff;
      if (write_acc) begin
         if (frame_ff == FRAME_LAST) begin
            frame_in = '0;
            wbc_in   = wbc_ff + WORD_W'(1);
         end else begin
            frame_in = frame_ff + FRAME_W'(1);
         end
         if (head_slot == SLOT_LAST) begin
            wrap_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         wbc_ff   <= '0;
         wrap_ff  <= 1'b0;
      end else begin
         frame_ff <= frame_in;
         wbc_ff   <= wbc_in;
         wrap_ff  <= wrap_in;
      end
   end

   // Store access: at most one write or one read per word
   assign sat_pair = {sat16(req_in_right), sat16(req_in_left)};
   assign rd_slot  = {req_read_block[RING_W-1:0], req_read_frame[FRAME_W-1:0]};
   // an entry holds data only once the head has passed it
   assign seen_in  = wrap_ff || (rd_slot < head_slot);

   always_ff @(posedge clock) begin
      if (write_acc) begin
         store_mem[head_slot] <= sat_pair;
      end
      if (read_acc) begin
         rd_data_ff <= store_mem[rd_slot];
      end
   end

   // Snapshot of the head and the press latency at accept
   always_comb begin
      if (wbc_ff >= WORD_W'(RING_BLOCKS)) begin
         avail_in = RING_W'(RING_BLOCKS - 1);
      end else if (wbc_ff == '0) begin
         avail_in = '0;
      end else begin
         avail_in = wbc_ff[RING_W-1:0] - RING_W'(1);
      end
      lat_in = (req_press_time_us != '0) ? (req_now_us - req_press_time_us) : '0;
      carry_in.op    = req_op;
      carry_in.wbc   = wbc_ff;
      carry_in.avail = avail_in;
      carry_in.lat   = lat_in;
      carry_in.data  = sat_pair;
   end

   // Pick the frame for the result: stored value, read value, or zero
   always_comb begin
      if (carry_ff[0].op == OP_WRITE) begin
         data_sel = carry_ff[0].data;
      end else if (carry_ff[0].op == OP_READ && seen_ff) begin
         data_sel = rd_data_ff;
      end else begin
         data_sel = '0;
      end
   end

   // Latency times rate, then divide by 1e6 over three stages
   assign prod_in = PROD_W'(carry_ff[0].lat) * PROD_W'(rate_ff);
   assign y_val   = prod_ff[PROD_W-1:DIV_PRE_SHIFT];
   assign pph_in  = PP_W'(y_val[Y_W-1:SPLIT]) * PP_W'(RECIP_W'(RECIP));
   assign ppl_in  = PP_W'(y_val[SPLIT-1:0]) * PP_W'(RECIP_W'(RECIP));
   assign sum_val = (SUM_W'(pph_ff) << SPLIT) + SUM_W'(ppl_ff);
   // estimate is low by at most one; the remainder tells
   assign qm_lo   = REM_W'(qe_ff[REM_W-1:0] * DIV_K);
   assign rem_val = ylo4_ff - qm_lo;
   assign q_in    = qe_ff + Q_W'(rem_val >= DIV_K);

   // Add the lag, round down to blocks, clamp to history
   assign back_val   = WORD_W'(lag_ff) + WORD_W'(q_ff);
   assign blocks_val = back_val[WORD_W-1:BLOCK_SHIFT];
   assign clamp_in   = blocks_val > BLK_W'(carry_ff[4].avail);
   assign blk_in     = clamp_in ? carry_ff[4].avail : blocks_val[RING_W-1:0];
   assign samples_val = SAMPLES_W'({blk_ff, {BLOCK_SHIFT{1'b0}}});

   // Pipeline valid bits and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[NSTAGE-2:0], acc};
         rsp_valid_ff <= vld_ff[NSTAGE-1];
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         carry_ff[0] <= carry_in;
         seen_ff     <= seen_in;
         carry_ff[1] <= '{op: carry_ff[0].op, wbc: carry_ff[0].wbc,
                          avail: carry_ff[0].avail, lat: carry_ff[0].lat, data: data_sel};
         for (int k = 2; k < NSTAGE; k++) begin
            carry_ff[k] <= carry_ff[k-1];
         end
         prod_ff  <= prod_in;
         pph_ff   <= pph_in;
         ppl_ff   <= ppl_in;
         ylo3_ff  <= y_val[REM_W-1:0];
         qe_ff    <= sum_val[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
         ylo4_ff  <= ylo3_ff;
         q_ff     <= q_in;
         blk_ff   <= blk_in;
         clamp_ff <= clamp_in;
      end
   end

   // Result register: hold while stalled
   always_ff @(posedge clock) begin
      if (adv) begin
         left_ff        <= '0;
         right_ff       <= '0;
         back_block_ff  <= '0;
         samples_ff     <= '0;
         was_clamped_ff <= 1'b0;
         latency_ff     <= '0;
         unique case (carry_ff[NSTAGE-1].op)
            OP_WRITE, OP_READ: begin
               left_ff  <= carry_ff[NSTAGE-1].data[SAMPLE_W-1:0];
               right_ff <= carry_ff[NSTAGE-1].data[ENTRY_W-1:SAMPLE_W];
            end
            OP_QUERY: begin
               back_block_ff  <= carry_ff[NSTAGE-1].wbc - WORD_W'(blk_ff);
               samples_ff     <= samples_val;
               was_clamped_ff <= clamp_ff;
               latency_ff     <= carry_ff[NSTAGE-1].lat;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_left         = left_ff;
   assign rsp_out_right        = right_ff;
   assign rsp_back_block       = back_block_ff;
   assign rsp_backdate_samples = samples_ff;
   assign rsp_was_clamped      = was_clamped_ff;
   assign rsp_press_latency_us = latency_ff;

   // Checks
   `AHRB_ASSERT_NEXT(a_block_advance, write_acc && frame_ff == FRAME_LAST, wbc_ff == $past(wbc_ff) + 32'd1, "block counter missed a full block")
   `AHRB_ASSERT_NEXT(a_head_hold, !write_acc, $stable(frame_ff) && $stable(wbc_ff), "write head moved without a write")
   `AHRB_ASSERT_NEXT(a_wrap_sticky, wrap_ff, wrap_ff, "wrap flag dropped")
   `AHRB_ASSERT_IMPLY(a_clamp_query_only, rsp_valid && rsp_was_clamped, rsp_out_left == 16'sd0 && rsp_out_right == 16'sd0, "clamp flag on a frame result")

endmodule
